// ----- sv/lhp_pkg.sv -----
// shared types and constants for the latency histogram percentile unit
`default_nettype none

package lhp_pkg;

  // widths of the item fields
  localparam int CNT_W     = 64;
  localparam int HALF_W    = 32;
  localparam int FRAC_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = FRAC_W + HALF_W;

  // bucket span: 60 s in microseconds, fits in ROOT_W bits
  localparam int ROOT_W = 26;
  localparam logic [ROOT_W-1:0] SPAN_US = 26'd60000000;

  // operation codes
  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // counter memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- sv/lhp_bounds.sv -----
// bucket bound rom: binning of a sample and floor bound lookup
`default_nettype none

module lhp_bounds #(
  parameter int BUCKETS = 64
) (
  input  wire logic [lhp_pkg::CNT_W-1:0]           bin_value,
  output logic      [$clog2(BUCKETS)-1:0]          bin_idx,
  input  wire logic [$clog2(BUCKETS+1)-1:0]        bound_idx,
  output logic      [lhp_pkg::CNT_W-1:0]           bound_value
);
  import lhp_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int BW = $clog2(BUCKETS+1);
  localparam int PW = ROOT_W * BUCKETS + 1;

  // x^BUCKETS by square and multiply
  function automatic logic [PW-1:0] pow_b(input logic [PW-1:0] x);
    logic [PW-1:0] r;
    r = PW'(1);
    for (int k = BW - 1; k >= 0; k--) begin
      r = r * r;
      if (((BUCKETS >> k) & 1) != 0) begin
        r = r * x;
      end
    end
    return r;
  endfunction

  // largest x with x^BUCKETS <= SPAN_US^i
  function automatic logic [CNT_W-1:0] floor_root(input int i);
    logic [PW-1:0]     span;
    logic [ROOT_W-1:0] lo;
    logic [ROOT_W-1:0] hi;
    logic [ROOT_W-1:0] mid;
    span = PW'(1);
    for (int k = 0; k < i; k++) begin
      span = span * PW'(SPAN_US);
    end
    lo = ROOT_W'(1);
    hi = SPAN_US;
    for (int s = 0; s <= ROOT_W; s++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + ROOT_W'(1)) >> 1);
        if (pow_b(PW'(mid)) <= span) begin
          lo = mid;
        end else begin
          hi = mid - ROOT_W'(1);
        end
      end
    end
    return CNT_W'(lo);
  endfunction

  logic [CNT_W-1:0]   floor_rom [BUCKETS+1];
  logic [BUCKETS-1:0] below;
  logic [BW-1:0]      below_cnt;

  for (genvar g = 0; g <= BUCKETS; g++) begin : g_rom
    localparam logic [CNT_W-1:0] FB = floor_root(g);
    assign floor_rom[g] = FB;
    if (g < BUCKETS) begin : g_ceil
      // ceiling bound: exact 1 for bucket 0, floor plus one otherwise
      localparam logic [CNT_W-1:0] CEIL = (g == 0) ? CNT_W'(1) : FB + CNT_W'(1);
      assign below[g] = (CEIL <= bin_value);
    end
  end

  // ceilings never decrease, so the bucket is the count of ceilings not above the sample
  always_comb begin
    below_cnt = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      below_cnt = below_cnt + BW'(below[i]);
    end
    if (below_cnt == BW'(BUCKETS)) begin
      bin_idx = IW'(BUCKETS - 1);
    end else begin
      bin_idx = below_cnt[IW-1:0];
    end
  end

  assign bound_value = floor_rom[bound_idx];

endmodule

`default_nettype wire

// ----- sv/lhp_count_mem.sv -----
// bucket counter memory; per-entry valid bits clear all entries at once
`default_nettype none

module lhp_count_mem #(
  parameter int BUCKETS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lhp_pkg::mem_ctl_t             ctl,
  input  wire logic [$clog2(BUCKETS)-1:0]    rd_addr,
  input  wire logic [$clog2(BUCKETS)-1:0]    wr_addr,
  input  wire logic [lhp_pkg::CNT_W-1:0]     wr_data,
  output logic      [lhp_pkg::CNT_W-1:0]     rd_data
);
  import lhp_pkg::*;

  logic [CNT_W-1:0]   mem [BUCKETS];
  logic [BUCKETS-1:0] valid_r;
  logic [CNT_W-1:0]   rd_q_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // an entry never written since clear reads as zero
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ----- sv/latency_histogram_percentile_unit.sv -----
// top level: latency histogram with geometric buckets and percentile query
//
// input channel (in_valid / in_ready) takes one item: in_func selects record (0),
// percentile query (1) or clear (2); code 3 changes nothing. every item gives
// exactly one result item on the output channel (out_valid / out_ready) carrying
// the query answer (zero for non-query items), sample count, wrapping latency sum
// and largest latency, all taken after the item's update.
// items are handled one at a time through the counter memory (one read port,
// one write port, registered read data); after the accepting edge each item
// goes through these steps until its result is loaded into the output register:
//   record: bin and read, write back, emit
//   query: multiply, target, scan of 0 to BUCKETS buckets, emit
//   clear and unused code: emit
// the next item is accepted on the cycle after the result is loaded into the
// output register, so the block keeps working while a result waits there.
// a stalled receiver holds the output register; the block stalls only when a
// second result is ready before the first is taken.
// reset empties the output register and zeroes all counters at once (valid bits
// on the bucket memory), so items are accepted from the first cycle after reset.

`default_nettype none

module latency_histogram_percentile_unit #(
  parameter int BUCKETS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_func,
  input  wire logic [lhp_pkg::CNT_W-1:0]         in_latency_us,
  input  wire logic [lhp_pkg::FRAC_W-1:0]        in_percentile_fraction,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [lhp_pkg::CNT_W-1:0]         out_percentile_value,
  output logic      [lhp_pkg::CNT_W-1:0]         out_sample_count,
  output logic      [lhp_pkg::CNT_W-1:0]         out_latency_sum,
  output logic      [lhp_pkg::CNT_W-1:0]         out_latency_max
);
  import lhp_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int BW = $clog2(BUCKETS+1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_WR,
    S_MUL,
    S_TGT,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // item and histogram totals
  logic [CNT_W-1:0]  lat_r, lat_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CNT_W-1:0]  tot_r, tot_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  max_r, max_nxt;

  // record and query working registers
  logic [IW-1:0]     bin_r, bin_nxt;
  logic [PROD_W-1:0] prod_hi_r, prod_hi_nxt;
  logic [PROD_W-1:0] prod_lo_r, prod_lo_nxt;
  logic [CNT_W-1:0]  tgt_r, tgt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]  cum_r, cum_nxt;
  logic [CNT_W-1:0]  pv_r, pv_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_pv_r, out_pv_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0]  out_sum_r, out_sum_nxt;
  logic [CNT_W-1:0]  out_max_r, out_max_nxt;

  // memory and rom hookup
  mem_ctl_t          mem_ctl;
  logic [IW-1:0]     rd_addr;
  logic [CNT_W-1:0]  wr_data;
  logic [CNT_W-1:0]  rd_data;
  logic [IW-1:0]     bin_idx;
  logic [BW-1:0]     bound_idx;
  logic [CNT_W-1:0]  bound_value;

  // target arithmetic
  logic [CNT_W-1:0]                hp;
  logic [PROD_W:0]                 lo_round;
  logic [PROD_W-FRAC_BITS:0]       lo_part;
  logic [CNT_W:0]                  tsum;
  logic [CNT_W-1:0]                cum_sum;

  lhp_bounds #(
    .BUCKETS (BUCKETS)
  ) u_bounds (
    .bin_value   (lat_r),
    .bin_idx     (bin_idx),
    .bound_idx   (bound_idx),
    .bound_value (bound_value)
  );

  lhp_count_mem #(
    .BUCKETS (BUCKETS)
  ) u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (bin_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign wr_data   = rd_data + CNT_W'(1);
  assign bound_idx = BW'(idx_r) + BW'(1);
  assign cum_sum   = cum_r + rd_data;

  // target = (p * hi) << 16 + ceil(p * lo / 2^16)
  assign hp       = {prod_hi_r[CNT_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign lo_round = {1'b0, prod_lo_r} + {{(PROD_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  assign lo_part  = lo_round[PROD_W:FRAC_BITS];
  assign tsum     = {1'b0, hp} + {{(CNT_W-PROD_W+FRAC_BITS){1'b0}}, lo_part};

  always_comb begin
    state_nxt     = state_r;
    lat_nxt       = lat_r;
    frac_nxt      = frac_r;
    tot_nxt       = tot_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    bin_nxt       = bin_r;
    prod_hi_nxt   = prod_hi_r;
    prod_lo_nxt   = prod_lo_r;
    tgt_nxt       = tgt_r;
    idx_nxt       = idx_r;
    cum_nxt       = cum_r;
    pv_nxt        = pv_r;
    out_valid_nxt = out_valid_r;
    out_pv_nxt    = out_pv_r;
    out_cnt_nxt   = out_cnt_r;
    out_sum_nxt   = out_sum_r;
    out_max_nxt   = out_max_r;
    mem_ctl       = '0;
    rd_addr       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lat_nxt  = in_latency_us;
          frac_nxt = in_percentile_fraction;
          pv_nxt   = '0;
          case (in_func)
            FUNC_RECORD: state_nxt = S_BIN;
            FUNC_QUERY:  state_nxt = S_MUL;
            FUNC_CLEAR: begin
              mem_ctl.clr = 1'b1;
              tot_nxt     = '0;
              sum_nxt     = '0;
              max_nxt     = '0;
              state_nxt   = S_EMIT;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_BIN: begin
        // read the bucket while the totals update
        mem_ctl.rd_en = 1'b1;
        rd_addr       = bin_idx;
        bin_nxt       = bin_idx;
        tot_nxt       = tot_r + CNT_W'(1);
        sum_nxt       = sum_r + lat_r;
        max_nxt       = (lat_r > max_r) ? lat_r : max_r;
        state_nxt     = S_WR;
      end
      S_WR: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_MUL: begin
        prod_hi_nxt = PROD_W'(frac_r) * PROD_W'(tot_r[CNT_W-1:HALF_W]);
        prod_lo_nxt = PROD_W'(frac_r) * PROD_W'(tot_r[HALF_W-1:0]);
        state_nxt   = S_TGT;
      end
      S_TGT: begin
        // first scan read goes out here
        mem_ctl.rd_en = 1'b1;
        rd_addr       = '0;
        idx_nxt       = '0;
        cum_nxt       = '0;
        tgt_nxt       = tsum[CNT_W-1:0];
        if (tot_r == '0) begin
          pv_nxt    = '0;
          state_nxt = S_EMIT;
        end else if (prod_hi_r[PROD_W-1] || tsum[CNT_W]) begin
          // target beyond 64 bits: no bucket can reach it
          pv_nxt    = max_r;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cum_sum >= tgt_r) begin
          pv_nxt    = bound_value;
          state_nxt = S_EMIT;
        end else if (idx_r == IW'(BUCKETS - 1)) begin
          pv_nxt    = max_r;
          state_nxt = S_EMIT;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_r + IW'(1);
          idx_nxt       = idx_r + IW'(1);
          cum_nxt       = cum_sum;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pv_nxt    = pv_r;
          out_cnt_nxt   = tot_r;
          out_sum_nxt   = sum_r;
          out_max_nxt   = max_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tot_r       <= '0;
      sum_r       <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tot_r       <= tot_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
    end
    lat_r     <= lat_nxt;
    frac_r    <= frac_nxt;
    bin_r     <= bin_nxt;
    prod_hi_r <= prod_hi_nxt;
    prod_lo_r <= prod_lo_nxt;
    tgt_r     <= tgt_nxt;
    idx_r     <= idx_nxt;
    cum_r     <= cum_nxt;
    pv_r      <= pv_nxt;
    out_pv_r  <= out_pv_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_sum_r <= out_sum_nxt;
    out_max_r <= out_max_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_pv_r;
  assign out_sample_count     = out_cnt_r;
  assign out_latency_sum      = out_sum_r;
  assign out_latency_max      = out_max_r;

endmodule

`default_nettype wire

// ----- sv/lhp_checker.sv -----
// port-level checks for the latency histogram percentile unit, bound to the top level
`default_nettype none

module lhp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_percentile_value,
  input wire logic [63:0] out_sample_count,
  input wire logic [63:0] out_latency_sum,
  input wire logic [63:0] out_latency_max
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_percentile_value)
      && $stable(out_sample_count) && $stable(out_latency_sum) && $stable(out_latency_max))
    else $error("stalled result item changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item in work");

  // an empty histogram answers zero
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_percentile_value != 64'd0 |-> out_sample_count != 64'd0)
    else $error("nonzero percentile with no samples");

  // all samples zero means a zero sum
  a_max_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_latency_max == 64'd0 |-> out_latency_sum == 64'd0)
    else $error("latency sum nonzero with zero maximum");

endmodule

bind latency_histogram_percentile_unit lhp_checker u_lhp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_percentile_value (out_percentile_value),
  .out_sample_count     (out_sample_count),
  .out_latency_sum      (out_latency_sum),
  .out_latency_max      (out_latency_max)
);

`default_nettype wire
